>>> hdl/tcer_pkg.sv
`timescale 1ns / 1ps

package tcer_pkg;

    // Bus decode
    localparam logic [15:0] ADDR_MASK     = 16'hF0F0;
    localparam logic [15:0] ADDR_TILT_ARM = 16'hA000;
    localparam logic [15:0] ADDR_TILT_LAT = 16'hA010;
    localparam logic [15:0] ADDR_X_LO     = 16'hA020;
    localparam logic [15:0] ADDR_X_HI     = 16'hA030;
    localparam logic [15:0] ADDR_Y_LO     = 16'hA040;
    localparam logic [15:0] ADDR_Y_HI     = 16'hA050;
    localparam logic [15:0] ADDR_PINS     = 16'hA080;

    // Gate keys and magic data values
    localparam logic [7:0]  GATE_A_KEY    = 8'h0A;
    localparam logic [7:0]  GATE_B_KEY    = 8'h40;
    localparam logic [7:0]  DATA_ARM      = 8'h55;
    localparam logic [7:0]  DATA_LATCH    = 8'hAA;
    localparam logic [7:0]  READ_IDLE     = 8'hFF;
    localparam logic [15:0] TILT_ARMED    = 16'h8000;
    localparam logic [15:0] TILT_BASE     = 16'h81D0;

    // Bus access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Pin bit positions in the pin byte
    localparam int PIN_DOUT = 0;
    localparam int PIN_DIN  = 1;
    localparam int PIN_CLK  = 6;
    localparam int PIN_SEL  = 7;

    // EEPROM geometry
    localparam int          EE_WORDS  = 128;
    localparam int          EE_AW     = 7;
    localparam int          WORD_W    = 16;
    localparam int          CMD_W     = 11;
    localparam int          BITS_W    = 5;
    localparam logic [15:0] WORD_ERASED = 16'hFFFF;
    localparam logic [4:0]  DATA_BITS   = 5'd16;

    // Microwire command kinds (command bits 9..6)
    localparam logic [3:0] KIND_READ  = 4'b10??;
    localparam logic [3:0] KIND_WRITE = 4'b01??;
    localparam logic [3:0] KIND_ERASE = 4'b11??;
    localparam logic [3:0] KIND_ERAL  = 4'b0010;
    localparam logic [3:0] KIND_WRAL  = 4'b0001;

    // Pin write from the bus decoder
    typedef struct packed {
        logic       strobe;
        logic [7:0] value;
    } pin_cmd_t;

    // EEPROM status back to the bus decoder
    typedef struct packed {
        logic busy;
        logic data_out;
        logic data_in;
        logic clock;
        logic select;
    } eep_status_t;

endpackage

>>> hdl/tcer_eeprom.sv
`timescale 1ns / 1ps

module tcer_eeprom
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcer_pkg::pin_cmd_t    pin_cmd,
    output tcer_pkg::eep_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_RMW   = 5'b00100,
        ST_CLEAR = 5'b01000,
        ST_OR    = 5'b10000
    } state_t;

    localparam logic [tcer_pkg::EE_AW-1:0] LAST_ADDR = tcer_pkg::EE_AW'(tcer_pkg::EE_WORDS - 1);

    state_t                          state_reg, state_next;
    logic                            dout_reg, dout_next;
    logic                            din_reg, din_next;
    logic                            clk_pin_reg, clk_pin_next;
    logic                            sel_reg, sel_next;
    logic [tcer_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [tcer_pkg::WORD_W-1:0]     rshift_reg, rshift_next;
    logic [tcer_pkg::BITS_W-1:0]     bits_reg, bits_next;
    logic [tcer_pkg::EE_AW-1:0]      op_addr_reg, op_addr_next;
    logic [tcer_pkg::WORD_W-1:0]     op_mask_reg, op_mask_next;
    logic [tcer_pkg::EE_WORDS-1:0]   valid_reg, valid_next;

    // Word storage, one write and one registered read per cycle
    logic [tcer_pkg::WORD_W-1:0]     mem [tcer_pkg::EE_WORDS];
    logic [tcer_pkg::WORD_W-1:0]     mem_rdata_reg;
    logic                            rd_valid_reg;
    logic                            mem_we;
    logic [tcer_pkg::EE_AW-1:0]      mem_waddr;
    logic [tcer_pkg::EE_AW-1:0]      mem_raddr;
    logic [tcer_pkg::WORD_W-1:0]     mem_wdata;

    logic [tcer_pkg::WORD_W-1:0]     rd_word;
    logic                            new_din;
    logic                            new_clk;
    logic                            new_sel;
    logic                            rise;
    logic [tcer_pkg::CMD_W-1:0]      cmd_in;
    logic [3:0]                      kind;
    logic [tcer_pkg::EE_AW-1:0]      idx;
    logic [tcer_pkg::BITS_W-1:0]     bits_dec;
    logic [tcer_pkg::WORD_W-1:0]     bit_mask;

    // Entries never written since reset or ERAL read as erased
    assign rd_word  = rd_valid_reg ? mem_rdata_reg : tcer_pkg::WORD_ERASED;

    assign new_din  = pin_cmd.value[tcer_pkg::PIN_DIN];
    assign new_clk  = pin_cmd.value[tcer_pkg::PIN_CLK];
    assign new_sel  = pin_cmd.value[tcer_pkg::PIN_SEL];
    assign rise     = new_sel && !clk_pin_reg && new_clk;
    assign cmd_in   = {cmd_reg[tcer_pkg::CMD_W-2:0], new_din};
    assign kind     = cmd_in[9:6];
    assign idx      = cmd_in[tcer_pkg::EE_AW-1:0];
    assign bits_dec = bits_reg - tcer_pkg::BITS_W'(1);
    assign bit_mask = tcer_pkg::WORD_W'(1) << bits_dec[3:0];

    // Pin protocol and memory sequencing
    always_comb
    begin
        state_next   = state_reg;
        dout_next    = dout_reg;
        din_next     = din_reg;
        clk_pin_next = clk_pin_reg;
        sel_next     = sel_reg;
        cmd_next     = cmd_reg;
        rshift_next  = rshift_reg;
        bits_next    = bits_reg;
        op_addr_next = op_addr_reg;
        op_mask_next = op_mask_reg;
        valid_next   = valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = op_addr_reg;
        mem_raddr    = op_addr_reg;
        mem_wdata    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pin_cmd.strobe)
                begin
                    sel_next     = new_sel;
                    din_next     = new_din;
                    clk_pin_next = new_clk;
                    if (rise)
                    begin
                        dout_next   = rshift_reg[tcer_pkg::WORD_W-1];
                        rshift_next = {rshift_reg[tcer_pkg::WORD_W-2:0], 1'b1};
                        if (bits_reg == '0)
                        begin
                            cmd_next = cmd_in;
                            if (cmd_in[tcer_pkg::CMD_W-1])
                            begin
                                // start bit seen: decode the command
                                unique casez (kind)
                                    tcer_pkg::KIND_READ:
                                    begin
                                        mem_raddr  = idx;
                                        cmd_next   = '0;
                                        state_next = ST_LOAD;
                                    end
                                    tcer_pkg::KIND_WRITE:
                                    begin
                                        mem_we          = 1'b1;
                                        mem_waddr       = idx;
                                        mem_wdata       = '0;
                                        valid_next[idx] = 1'b1;
                                        bits_next       = tcer_pkg::DATA_BITS;
                                    end
                                    tcer_pkg::KIND_ERASE:
                                    begin
                                        mem_we          = 1'b1;
                                        mem_waddr       = idx;
                                        mem_wdata       = tcer_pkg::WORD_ERASED;
                                        valid_next[idx] = 1'b1;
                                        cmd_next        = '0;
                                    end
                                    tcer_pkg::KIND_ERAL:
                                    begin
                                        valid_next = '0;
                                        cmd_next   = '0;
                                    end
                                    tcer_pkg::KIND_WRAL:
                                    begin
                                        valid_next   = '1;
                                        op_addr_next = '0;
                                        bits_next    = tcer_pkg::DATA_BITS;
                                        state_next   = ST_CLEAR;
                                    end
                                    default:
                                    begin
                                        // EWEN, EWDS and unused kinds
                                        cmd_next = '0;
                                    end
                                endcase
                            end
                        end
                        else
                        begin
                            // data phase of WRITE or WRAL
                            bits_next = bits_dec;
                            dout_next = 1'b1;
                            if (new_din)
                            begin
                                op_mask_next = bit_mask;
                                if (cmd_reg[8])
                                begin
                                    mem_raddr    = cmd_reg[tcer_pkg::EE_AW-1:0];
                                    op_addr_next = cmd_reg[tcer_pkg::EE_AW-1:0];
                                    state_next   = ST_RMW;
                                end
                                else
                                begin
                                    mem_raddr    = '0;
                                    op_addr_next = '0;
                                    state_next   = ST_OR;
                                end
                            end
                            if (bits_dec == '0)
                            begin
                                cmd_next = '0;
                            end
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                rshift_next = rd_word;
                state_next  = ST_IDLE;
            end
            ST_RMW:
            begin
                mem_we                  = 1'b1;
                mem_waddr               = op_addr_reg;
                mem_wdata               = rd_word | op_mask_reg;
                valid_next[op_addr_reg] = 1'b1;
                state_next              = ST_IDLE;
            end
            ST_CLEAR:
            begin
                // WRAL preclear, one word per cycle
                mem_we       = 1'b1;
                mem_waddr    = op_addr_reg;
                mem_wdata    = '0;
                op_addr_next = op_addr_reg + tcer_pkg::EE_AW'(1);
                if (op_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OR:
            begin
                // WRAL data bit: write word n while word n+1 is read
                mem_we                  = 1'b1;
                mem_waddr               = op_addr_reg;
                mem_wdata               = rd_word | op_mask_reg;
                valid_next[op_addr_reg] = 1'b1;
                mem_raddr               = op_addr_reg + tcer_pkg::EE_AW'(1);
                op_addr_next            = op_addr_reg + tcer_pkg::EE_AW'(1);
                if (op_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dout_reg    <= 1'b0;
            din_reg     <= 1'b0;
            clk_pin_reg <= 1'b0;
            sel_reg     <= 1'b0;
            cmd_reg     <= '0;
            rshift_reg  <= '0;
            bits_reg    <= '0;
            valid_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            dout_reg    <= dout_next;
            din_reg     <= din_next;
            clk_pin_reg <= clk_pin_next;
            sel_reg     <= sel_next;
            cmd_reg     <= cmd_next;
            rshift_reg  <= rshift_next;
            bits_reg    <= bits_next;
            valid_reg   <= valid_next;
        end
    end

    // Operation payload
    always_ff @(posedge clk)
    begin
        op_addr_reg <= op_addr_next;
        op_mask_reg <= op_mask_next;
    end

    // Word memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
        rd_valid_reg  <= valid_reg[mem_raddr];
    end

    assign status.busy     = (state_reg != ST_IDLE);
    assign status.data_out = dout_reg;
    assign status.data_in  = din_reg;
    assign status.clock    = clk_pin_reg;
    assign status.select   = sel_reg;

endmodule

>>> hdl/tilt_cart_eeprom_registers.sv
// Cartridge register block: each bus access arrives as one slave-stream
// transaction and a read returns one master-stream transaction with the byte.
// A pin write at 0xA080 that completes a READ command, or clocks a WRITE data
// bit of 1, holds off the next transaction while the EEPROM loads or updates
// that word; a WRAL command, and each WRAL data bit of 1, hold it off while the
// single write port of the 128-word EEPROM memory sweeps every word, one word
// per cycle. ERAL does not hold off the next transaction.
// The two gate registers sit on the APB port at offsets 0x0 and 0x4.
`timescale 1ns / 1ps

module tilt_cart_eeprom_registers
(
    input  logic        clk,
    input  logic        rst_n,

    // bus access transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // bus_address[15:0], write_data[23:16],
                                   // tilt_x[36:24], tilt_y[49:37], zero pad
    input  logic        s_tuser,   // op (0 read, 1 write)

    // read results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_data[7:0]

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]            gate_a_reg, gate_a_next;
    logic [7:0]            gate_b_reg, gate_b_next;
    logic [15:0]           tilt_x_reg, tilt_x_next;
    logic [15:0]           tilt_y_reg, tilt_y_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_data_reg, m_data_next;

    logic                  apb_wr;
    logic                  in_acc;
    logic                  gate_open;
    logic [15:0]           sel_addr;
    logic [7:0]            wdata;
    logic signed [12:0]    tx;
    logic signed [12:0]    ty;
    logic [7:0]            rd_byte;
    tcer_pkg::pin_cmd_t    pin_cmd;
    tcer_pkg::eep_status_t eep_status;

    assign sel_addr  = s_tdata[15:0] & tcer_pkg::ADDR_MASK;
    assign wdata     = s_tdata[23:16];
    assign tx        = s_tdata[36:24];
    assign ty        = s_tdata[49:37];
    assign gate_open = (gate_a_reg == tcer_pkg::GATE_A_KEY) &&
                       (gate_b_reg == tcer_pkg::GATE_B_KEY);

    // Writes never produce a result, so they pass a waiting read result
    assign s_tready = !eep_status.busy &&
                      ((s_tuser == tcer_pkg::OP_WRITE) || !m_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;

    // APB gate registers
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {24'd0, gate_b_reg} : {24'd0, gate_a_reg};

    always_comb
    begin
        gate_a_next = gate_a_reg;
        gate_b_next = gate_b_reg;
        if (apb_wr)
        begin
            if (paddr[2])
            begin
                gate_b_next = pwdata[7:0];
            end
            else
            begin
                gate_a_next = pwdata[7:0];
            end
        end
    end

    // Read decode
    always_comb
    begin
        rd_byte = tcer_pkg::READ_IDLE;
        if (gate_open)
        begin
            priority if (sel_addr == tcer_pkg::ADDR_X_LO)
                rd_byte = tilt_x_reg[7:0];
            else if (sel_addr == tcer_pkg::ADDR_X_HI)
                rd_byte = tilt_x_reg[15:8];
            else if (sel_addr == tcer_pkg::ADDR_Y_LO)
                rd_byte = tilt_y_reg[7:0];
            else if (sel_addr == tcer_pkg::ADDR_Y_HI)
                rd_byte = tilt_y_reg[15:8];
            else if (sel_addr == tcer_pkg::ADDR_PINS)
                rd_byte = {eep_status.select, eep_status.clock, 4'b0000,
                           eep_status.data_in, eep_status.data_out};
        end
    end

    // Write decode: tilt latches and EEPROM pins
    always_comb
    begin
        tilt_x_next    = tilt_x_reg;
        tilt_y_next    = tilt_y_reg;
        pin_cmd.strobe = 1'b0;
        pin_cmd.value  = wdata;
        if (in_acc && (s_tuser == tcer_pkg::OP_WRITE) && gate_open)
        begin
            priority if ((sel_addr == tcer_pkg::ADDR_TILT_ARM) &&
                         (wdata == tcer_pkg::DATA_ARM))
            begin
                tilt_x_next = tcer_pkg::TILT_ARMED;
                tilt_y_next = tcer_pkg::TILT_ARMED;
            end
            else if ((sel_addr == tcer_pkg::ADDR_TILT_LAT) &&
                     (wdata == tcer_pkg::DATA_LATCH))
            begin
                tilt_x_next = tcer_pkg::TILT_BASE + 16'(tx);
                tilt_y_next = tcer_pkg::TILT_BASE + 16'(ty);
            end
            else if (sel_addr == tcer_pkg::ADDR_PINS)
            begin
                pin_cmd.strobe = 1'b1;
            end
        end
    end

    // Output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (in_acc && (s_tuser == tcer_pkg::OP_READ))
        begin
            m_valid_next = 1'b1;
            m_data_next  = rd_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_a_reg  <= '0;
            gate_b_reg  <= '0;
            tilt_x_reg  <= '0;
            tilt_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            gate_a_reg  <= gate_a_next;
            gate_b_reg  <= gate_b_next;
            tilt_x_reg  <= tilt_x_next;
            tilt_y_reg  <= tilt_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    tcer_eeprom u_eeprom
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pin_cmd (pin_cmd),
        .status  (eep_status)
    );

endmodule
